>>> hw/rtl/alm_pkg.sv
// ----------------------------------------------------------------------------
// alm_pkg: shared types and constants for the audio level meter
// table of x^0.7 over [0,0.5] in q15 and fixed widths
// ----------------------------------------------------------------------------
`default_nettype none
package alm_pkg;
	localparam int SampleW = 16;
	localparam int OutW    = 16;
	localparam logic CmdSample = 1'b0;
	localparam logic CmdFrame  = 1'b1;

	// data handed from one window cell to the next
	typedef struct packed {
		logic        valid;
		logic [16:0] mag;
	} alm_peak_t;

	function automatic logic [14:0] pow07_q15(input logic [5:0] idx);
		logic [14:0] r;
		begin
			case (idx)
				6'd0: r = 15'd0;      6'd1: r = 15'd1783;   6'd2: r = 15'd2896;
				6'd3: r = 15'd3847;   6'd4: r = 15'd4705;   6'd5: r = 15'd5501;
				6'd6: r = 15'd6249;   6'd7: r = 15'd6961;   6'd8: r = 15'd7643;
				6'd9: r = 15'd8300;   6'd10: r = 15'd8936;  6'd11: r = 15'd9552;
				6'd12: r = 15'd10152; 6'd13: r = 15'd10737; 6'd14: r = 15'd11309;
				6'd15: r = 15'd11868; 6'd16: r = 15'd12417; 6'd17: r = 15'd12955;
				6'd18: r = 15'd13484; 6'd19: r = 15'd14004; 6'd20: r = 15'd14516;
				6'd21: r = 15'd15020; 6'd22: r = 15'd15517; 6'd23: r = 15'd16008;
				6'd24: r = 15'd16492; 6'd25: r = 15'd16970; 6'd26: r = 15'd17442;
				6'd27: r = 15'd17909; 6'd28: r = 15'd18371; 6'd29: r = 15'd18828;
				6'd30: r = 15'd19280; 6'd31: r = 15'd19728; 6'd32: r = 15'd20171;
				default: r = 15'd0;
			endcase
			return r;
		end
	endfunction

	// floor(x/10) by reciprocal multiply, one step of correction
	function automatic logic [23:0] div10(input logic [23:0] x);
		logic [47:0] m;
		logic [23:0] q;
		begin
			m = 48'(x) * 48'd1677722;
			q = m[47:24];
			if (28'(q) * 28'd10 > 28'(x)) q = q - 24'd1;
			return q;
		end
	endfunction
endpackage
`default_nettype wire

>>> hw/rtl/alm_cell.sv
// ----------------------------------------------------------------------------
// alm_cell: one window entry of the sample chain
// moves its sample to the neighbor on shift; always passes the running peak
// ----------------------------------------------------------------------------
`default_nettype none
module alm_cell
	import alm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        shift,
	input  wire logic [15:0] smp_in,
	output logic      [15:0] smp_out,
	input  alm_peak_t        pk_in,
	output alm_peak_t        pk_out
);
	logic [15:0] smp_q;
	logic [16:0] mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_q  <= '0;
			pk_out <= '0;
		end else begin
			if (shift) smp_q <= smp_in;
			pk_out.valid <= pk_in.valid;
			pk_out.mag   <= (mag > pk_in.mag) ? mag : pk_in.mag;
		end
	end

	assign mag     = smp_q[15] ? (17'h10000 - {1'b0, smp_q}) : {1'b0, smp_q};
	assign smp_out = smp_q;
endmodule
`default_nettype wire

>>> hw/rtl/alm_divider.sv
// ----------------------------------------------------------------------------
// alm_divider: restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module alm_divider
	import alm_pkg::*;
#(
	parameter int NumW = 40,
	parameter int DenW = 20
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NumW-1:0] num,
	input  wire logic [DenW-1:0] den,
	output logic                 done,
	output logic      [NumW-1:0] quo
);
	localparam int CntW = $clog2(NumW + 1);
	logic [NumW-1:0] q_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [DenW:0]   trial;

	assign trial = {rem_q[DenW-1:0], q_q[NumW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				q_q   <= {q_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign quo = q_q;
endmodule
`default_nettype wire

>>> hw/rtl/audio_level_meter.sv
// audio_level_meter: waveform level meter in unsigned q1.15
// sample transaction: shifts the sample in while the window is not full; a chunk end adds the peak walk down
//   the cell chain, then compare-and-subtract steps for the /50000 scaling
// frame transaction: peak/threshold update, serial divider, shape, smooth and display steps, to the result
// one transaction in flight; the result waits in an output register, a later frame stalls
//   in its last step until it is taken; async active-low reset clears all but scratch regs
`default_nettype none
module audio_level_meter
	import alm_pkg::*;
#(
	parameter int WINDOW       = 160,
	parameter int ADAPT_FRAMES = 100
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [15:0] sample
	input  wire logic        s_tlast,   // chunk_end
	input  wire logic        s_tuser,   // cmd
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata    // [15:0] level, [31:16] power
);
	localparam int PosW = $clog2(WINDOW + 1);
	localparam int FcW  = $clog2(ADAPT_FRAMES + 1);
	localparam logic [16:0] One = 17'd32768;

	// controller states
	localparam logic [3:0] StIdle = 4'd0, StWalk = 4'd1, StNorm = 4'd2,
		StFrame = 4'd3, StDiv = 4'd4, StShape = 4'd5, StSmooth = 4'd6,
		StDisp = 4'd7, StOut = 4'd8, StShape2 = 4'd9, StEmit = 4'd10;

	logic [3:0]      state_q;
	logic [PosW-1:0] fill_q, cnt_q;
	logic [FcW-1:0]  frame_q;
	logic [16:0]     power_q, peak_q, thr_q, smooth_q, disp_q, n_q, e_q;
	logic [31:0]     norm_q;   // mx*32768 + 25000 being reduced by 50000
	logic [16:0]     pq_q;     // quotient counter for power
	logic            acc;
	logic            launch_q; // starts the peak walk in the cycle after the chunk end
	logic [31:0]     res_q;    // held result transaction
	logic            emit;

	assign acc      = s_tvalid && s_tready;
	assign s_tready = (state_q == StIdle);

	// cell chain: shifts a new sample in, walks the peak down the row
	logic [15:0]     smp [WINDOW+1];
	alm_peak_t       pk  [WINDOW+1];
	logic            shift;
	assign shift  = acc && (s_tuser == CmdSample) && (fill_q < PosW'(WINDOW));
	assign smp[0] = s_tdata;
	assign pk[0]  = '{valid: launch_q, mag: 17'd0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= 1'b0;
		end else begin
			launch_q <= acc && (s_tuser == CmdSample) && s_tlast;
		end
	end

	for (genvar g = 0; g < WINDOW; g++) begin : g_cell
		// the peak enters after the shift of the same cycle, so it is launched in the cycle after
		alm_cell u_cell (
			.clk(clk), .arst_n(arst_n), .shift(shift),
			.smp_in(smp[g]), .smp_out(smp[g+1]), .pk_in(pk[g]), .pk_out(pk[g+1])
		);
	end

	// divider for n = p*5*32768 / (6*thr)
	logic        div_start, div_done;
	logic [35:0] div_num, div_quo;
	logic [19:0] div_den;
	assign div_num = {2'b0, power_q, 17'd0} + {4'b0, power_q, 15'd0};
	assign div_den = 20'({thr_q, 1'b0}) + 20'({thr_q, 2'b0});
	alm_divider #(.NumW(36), .DenW(20)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);
	assign div_start = (state_q == StFrame);

	// shape helpers: 32 segments over [0,0.5), 9 fraction bits each
	logic [5:0]  idx;
	logic [14:0] t_lo, t_hi;
	logic [8:0]  frac;
	logic [25:0] slope;
	assign idx   = {1'b0, n_q[13:9]};
	assign frac  = n_q[8:0];
	assign t_lo  = pow07_q15(idx);
	assign t_hi  = pow07_q15(idx + 6'd1);
	assign slope = 26'(t_hi - t_lo) * 26'(frac);
	logic [20:0] lin;   // (n-0.5)*13
	assign lin = 21'(n_q - 17'd16384) * 21'd13;

	logic [23:0] sm_num;
	logic [24:0] dp_num;
	assign sm_num = 24'(e_q) * 24'd6 + 24'(smooth_q) * 24'd4 + 24'd5;
	assign dp_num = (smooth_q > disp_q) ?
		25'(smooth_q) * 25'd85 + 25'(disp_q) * 25'd15 + 25'd50 :
		25'(smooth_q) * 25'd30 + 25'(disp_q) * 25'd70 + 25'd50;

	// division by constant via reciprocal multiply with correction
	logic [16:0] sm_div, dp_div, adapt_thr, peak09;
	logic [23:0] sm_chk; logic [24:0] dp_chk;
	logic [47:0] sm_m; logic [49:0] dp_m;
	assign sm_m   = 48'(sm_num) * 48'd1677722;   // 2^24/10 rounded up
	assign sm_div = 17'(sm_m >> 24);
	assign dp_m   = 50'(dp_num) * 50'd167773;    // 2^24/100 rounded up
	assign dp_div = 17'(dp_m >> 24);
	logic [16:0] sm_fix, dp_fix;
	assign sm_chk = 24'(sm_div) * 24'd10;
	assign dp_chk = 25'(dp_div) * 25'd100;
	assign sm_fix = (sm_chk > sm_num) ? sm_div - 17'd1 : sm_div;
	assign dp_fix = (dp_chk > dp_num) ? dp_div - 17'd1 : dp_div;
	logic [16:0] dec07;
	assign dec07 = 17'(div10(24'(disp_q) * 24'd7));

	logic [16:0] pk_new;
	logic [18:0] thr_num;   // peak*3 + 10, halved below to get /20
	assign pk_new    = (power_q > peak_q) ? power_q : peak_q;
	assign thr_num   = 19'(pk_new) * 19'd3 + 19'd10;
	assign adapt_thr = 17'(div10(24'(thr_num[18:1])));
	assign peak09    = 17'(div10(24'(pk_new) * 24'd9));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= StIdle;
			fill_q   <= '0;
			cnt_q    <= '0;
			frame_q  <= '0;
			power_q  <= '0;
			peak_q   <= '0;
			thr_q    <= 17'd328;
			smooth_q <= '0;
			disp_q   <= '0;
		end else begin
			unique case (state_q)
				StIdle: if (acc) begin
					if (s_tuser == CmdSample) begin
						if (s_tlast) begin
							fill_q  <= '0;
							cnt_q   <= '0;
							state_q <= StWalk;
						end else if (shift) fill_q <= fill_q + 1'b1;
					end else begin
						state_q <= StFrame;
						if (frame_q + 1'b1 >= FcW'(ADAPT_FRAMES)) begin
							frame_q <= '0;
							thr_q   <= (adapt_thr < 17'd98) ? 17'd98 : adapt_thr;
							peak_q  <= peak09;
						end else begin
							frame_q <= frame_q + 1'b1;
							peak_q  <= pk_new;
						end
					end
				end
				StWalk: if (pk[WINDOW].valid) begin
					norm_q  <= 32'({pk[WINDOW].mag, 15'd0}) + 32'd25000;
					pq_q    <= '0;
					state_q <= StNorm;
				end
				StNorm: begin
					// subtract 50000 per step, or 64 of them at once while the rest is large
					if (norm_q >= 32'd3200000) begin
						norm_q <= norm_q - 32'd3200000; pq_q <= pq_q + 17'd64;
					end else if (norm_q >= 32'd50000) begin
						norm_q <= norm_q - 32'd50000; pq_q <= pq_q + 17'd1;
					end else begin
						power_q <= (pq_q > One) ? One : pq_q;
						state_q <= StIdle;
					end
				end
				StFrame: state_q <= StDiv;
				StDiv: if (div_done) begin
					n_q     <= (div_quo > 36'(One)) ? One : div_quo[16:0];
					state_q <= StShape;
				end
				StShape: begin
					if (n_q < 17'd16384)
						e_q <= 17'(t_lo) + 17'((slope + 26'd256) >> 9);
					else
						e_q <= 17'd10085 + 17'(div10(24'(lin) + 24'd5));
					state_q <= StShape2;
				end
				StShape2: begin
					if (e_q > One) e_q <= One;
					state_q <= StSmooth;
				end
				StSmooth: begin
					smooth_q <= sm_fix;
					state_q  <= StDisp;
				end
				StDisp: begin
					disp_q  <= dp_fix;
					state_q <= StOut;
				end
				StOut: begin
					disp_q  <= (disp_q < 17'd983) ? dec07 : ((disp_q > One) ? One : disp_q);
					state_q <= StEmit;
				end
				StEmit: if (emit) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	// output register: loads when empty or being drained this cycle
	assign emit = (state_q == StEmit) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			res_q    <= '0;
		end else begin
			if (emit) begin
				m_tvalid <= 1'b1;
				res_q    <= {power_q[15:0], disp_q[15:0]};
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	assign m_tdata = res_q;

	// one result per frame: the output register never reloads while still held
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= PosW'(WINDOW)) else $error("chunk fill overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> state_q == StIdle) else $error("accept while busy");
endmodule
`default_nettype wire
